@@ hdl/ostt_pkg.sv @@
// Package for the one-shot timer table: sizes, command and report codes,
// slot entry and report structures.
// No dependencies.
`default_nettype none

package ostt_pkg;

    // Table size and derived index widths
    localparam int SLOTS      = 5;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(SLOTS + 1);

    localparam int ID_W   = 8;
    localparam int TIME_W = 32;

    // Command carried on the input tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Report kind carried on the output tuser
    typedef enum logic [1:0] {
        KIND_SET_OK   = 2'd0,
        KIND_SET_FULL = 2'd1,
        KIND_EXPIRED  = 2'd2
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One slot as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   id;
    } slot_entry_t;

    // One report beat
    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rpt_time;
        logic              last;
    } report_t;

endpackage

`default_nettype wire

@@ hdl/ostt_slot_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with
// registered read data.
// No dependencies.
`default_nettype none

module ostt_slot_ram #(
    parameter int DEPTH = 5,
    parameter int WIDTH = 40,
    parameter int AW    = 3
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/one_shot_timer_table_top.sv @@
// Top level of the one-shot timer table: command sequencer, slot valid
// flags, millisecond counter and output beat register.
// Depends on ostt_pkg and ostt_slot_ram.
//
//  channel   direction  tdata (low bit up)            tuser           tlast
//  s_axis    in         timer_id, delay_ms            command         -
//  m_axis    out        report_id, report_time        report_kind     last_report
//
// One beat is taken, then the slot memory is read one slot a cycle (while no
// tick stall holds), set by its single read port, with the compare on the
// registered read data, then a closing state; the next beat waits for idle.
// Reset empties every slot and zeroes the counter at once; no clearing pass.
// A tick stalls its scan while a second expiry waits on a stalled m_axis;
// a set waits in its closing cycle until the output register is free.
`default_nettype none

module one_shot_timer_table_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // timer_id[7:0], delay_ms[39:8]
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // report_id[7:0], report_time[39:8]
    output logic      [1:0]  m_axis_tuser,   // report_kind[1:0]
    output logic             m_axis_tlast    // last_report
);

    import ostt_pkg::*;

    // Control registers
    state_t                  state_reg,       state_next;
    cmd_t                    cmd_reg,         cmd_next;
    logic [TIME_W-1:0]       ms_count_reg,    ms_count_next;
    logic [SLOTS-1:0]        valid_reg,       valid_next;
    logic [SLOT_CNT_W-1:0]   rd_cnt_reg,      rd_cnt_next;
    logic                    chk_vld_reg,     chk_vld_next;
    logic                    found_reg,       found_next;
    logic                    empty_found_reg, empty_found_next;
    logic                    pend_vld_reg,    pend_vld_next;
    logic                    out_vld_reg,     out_vld_next;

    // Payload registers
    logic [ID_W-1:0]         id_reg,          id_next;
    logic [TIME_W-1:0]       deadline_reg,    deadline_next;
    logic [SLOT_IDX_W-1:0]   chk_idx_reg,     chk_idx_next;
    logic [SLOT_IDX_W-1:0]   found_idx_reg,   found_idx_next;
    logic [SLOT_IDX_W-1:0]   empty_idx_reg,   empty_idx_next;
    report_t                 pend_reg,        pend_next;
    report_t                 out_reg,         out_next;

    // Slot memory ports
    logic                    rd_en;
    logic [SLOT_IDX_W-1:0]   rd_addr;
    logic                    wr_en;
    logic [SLOT_IDX_W-1:0]   wr_addr;
    slot_entry_t             wr_entry;
    slot_entry_t             rd_entry;
    logic [$bits(slot_entry_t)-1:0] rd_word;

    ostt_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH ($bits(slot_entry_t)),
        .AW    (SLOT_IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = slot_entry_t'(rd_word);

    // Port drive
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg.rpt_time, out_reg.id};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

    // Sequencer: next state and datapath
    always_comb
    begin
        logic              out_free;
        logic              hit;
        logic              stall;
        logic              load_out;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] dur_eff;

        state_next       = state_reg;
        cmd_next         = cmd_reg;
        ms_count_next    = ms_count_reg;
        valid_next       = valid_reg;
        rd_cnt_next      = rd_cnt_reg;
        chk_vld_next     = chk_vld_reg;
        found_next       = found_reg;
        empty_found_next = empty_found_reg;
        pend_vld_next    = pend_vld_reg;
        id_next          = id_reg;
        deadline_next    = deadline_reg;
        chk_idx_next     = chk_idx_reg;
        found_idx_next   = found_idx_reg;
        empty_idx_next   = empty_idx_reg;
        pend_next        = pend_reg;
        out_next         = out_reg;
        load_out         = 1'b0;

        rd_en    = 1'b0;
        rd_addr  = rd_cnt_reg[SLOT_IDX_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = found_reg ? found_idx_reg : empty_idx_reg;
        wr_entry = '{deadline: deadline_reg, id: id_reg};

        out_free = !out_vld_reg || m_axis_tready;
        dur      = s_axis_tdata[39:8];
        dur_eff  = (dur == '0) ? TIME_W'(1) : dur;

        // Compare of the slot read last, held in the registered read data
        if (cmd_reg == CMD_TICK)
        begin
            hit = chk_vld_reg && valid_reg[chk_idx_reg]
                  && (rd_entry.deadline == ms_count_reg);
        end
        else
        begin
            hit = chk_vld_reg && valid_reg[chk_idx_reg] && (rd_entry.id == id_reg);
        end
        stall = (cmd_reg == CMD_TICK) && hit && pend_vld_reg && !out_free;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next         = cmd_t'(s_axis_tuser);
                    id_next          = s_axis_tdata[7:0];
                    deadline_next    = ms_count_reg + dur_eff;
                    rd_cnt_next      = '0;
                    chk_vld_next     = 1'b0;
                    found_next       = 1'b0;
                    empty_found_next = 1'b0;
                    pend_vld_next    = 1'b0;
                    if (s_axis_tuser inside {CMD_SET, CMD_CLEAR})
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (s_axis_tuser == CMD_TICK)
                    begin
                        ms_count_next = ms_count_reg + TIME_W'(1);
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    // Check stage
                    if (chk_vld_reg)
                    begin
                        if (cmd_reg == CMD_TICK)
                        begin
                            if (hit)
                            begin
                                valid_next[chk_idx_reg] = 1'b0;
                                if (pend_vld_reg)
                                begin
                                    load_out = 1'b1;
                                    out_next = pend_reg;
                                end
                                pend_next     = '{kind: KIND_EXPIRED, id: rd_entry.id,
                                                  rpt_time: ms_count_reg, last: 1'b0};
                                pend_vld_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (hit && !found_reg)
                            begin
                                found_next     = 1'b1;
                                found_idx_next = chk_idx_reg;
                            end
                            if (!valid_reg[chk_idx_reg] && !empty_found_reg)
                            begin
                                empty_found_next = 1'b1;
                                empty_idx_next   = chk_idx_reg;
                            end
                        end
                    end

                    // Read stage
                    if (rd_cnt_reg < SLOT_CNT_W'(SLOTS))
                    begin
                        rd_en        = 1'b1;
                        chk_vld_next = 1'b1;
                        chk_idx_next = rd_cnt_reg[SLOT_IDX_W-1:0];
                        rd_cnt_next  = rd_cnt_reg + SLOT_CNT_W'(1);
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (!pend_vld_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            load_out      = 1'b1;
                            out_next      = pend_reg;
                            out_next.last = 1'b1;
                            pend_vld_next = 1'b0;
                            state_next    = ST_IDLE;
                        end
                    end

                    CMD_SET:
                    begin
                        if (out_free)
                        begin
                            load_out = 1'b1;
                            if (found_reg || empty_found_reg)
                            begin
                                wr_en               = 1'b1;
                                valid_next[wr_addr] = 1'b1;
                                out_next = '{kind: KIND_SET_OK, id: id_reg,
                                             rpt_time: ms_count_reg, last: 1'b1};
                            end
                            else
                            begin
                                out_next = '{kind: KIND_SET_FULL, id: id_reg,
                                             rpt_time: ms_count_reg, last: 1'b1};
                            end
                            state_next = ST_IDLE;
                        end
                    end

                    CMD_CLEAR:
                    begin
                        if (found_reg)
                        begin
                            valid_next[found_idx_reg] = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: load or drain
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= CMD_TICK;
            ms_count_reg    <= '0;
            valid_reg       <= '0;
            rd_cnt_reg      <= '0;
            chk_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            pend_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            ms_count_reg    <= ms_count_next;
            valid_reg       <= valid_next;
            rd_cnt_reg      <= rd_cnt_next;
            chk_vld_reg     <= chk_vld_next;
            found_reg       <= found_next;
            empty_found_reg <= empty_found_next;
            pend_vld_reg    <= pend_vld_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        deadline_reg  <= deadline_next;
        chk_idx_reg   <= chk_idx_next;
        found_idx_reg <= found_idx_next;
        empty_idx_reg <= empty_idx_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

@@ verif/ostt_report_check.sv @@
// Report checker for the one-shot timer table: watches both stream channels,
// keeps its own copy of the slot table and counter, and compares every report.
// Depends on ostt_pkg.

module ostt_report_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // timer_id[7:0], delay_ms[39:8]
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // report_id[7:0], report_time[39:8]
    input  wire logic [1:0]  m_axis_tuser,   // report_kind[1:0]
    input  wire logic        m_axis_tlast,   // last_report
    output int               fail_count,
    output int               pending,
    output int               expiries,
    output int               rejects
);

    import ostt_pkg::*;

    // Shadow of the timer table
    logic [TIME_W-1:0] ms_now;
    logic              slot_live  [SLOTS];
    logic [ID_W-1:0]   slot_owner [SLOTS];
    logic [TIME_W-1:0] slot_due   [SLOTS];

    // Reports still owed by the block, oldest first
    report_t           owed_reports[$];

    // Work out the reports caused by one accepted command beat
    task automatic apply_command(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] dur);
        int      hit;
        int      spare;
        int      last_hit;
        report_t rep;
        hit      = -1;
        spare    = -1;
        last_hit = -1;
        case (cmd)
            CMD_TICK:
            begin
                ms_now = ms_now + 1'b1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && slot_due[i] == ms_now)
                        last_hit = i;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_live[i] && slot_due[i] == ms_now)
                    begin
                        slot_live[i] = 1'b0;
                        rep.kind     = KIND_EXPIRED;
                        rep.id       = slot_owner[i];
                        rep.rpt_time = ms_now;
                        rep.last     = (i == last_hit);
                        owed_reports.push_back(rep);
                    end
                end
            end
            CMD_SET:
            begin
                if (dur == '0)
                    dur = 1;
                // same id first, else lowest empty slot
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (slot_live[i] && slot_owner[i] == id)
                        hit = i;
                    if (!slot_live[i])
                        spare = i;
                end
                if (hit < 0)
                    hit = spare;
                rep.id       = id;
                rep.rpt_time = ms_now;
                rep.last     = 1'b1;
                if (hit < 0)
                    rep.kind = KIND_SET_FULL;
                else
                begin
                    rep.kind        = KIND_SET_OK;
                    slot_live[hit]  = 1'b1;
                    slot_owner[hit] = id;
                    slot_due[hit]   = ms_now + dur;
                end
                owed_reports.push_back(rep);
            end
            CMD_CLEAR:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_live[i] && slot_owner[i] == id)
                        hit = i;
                if (hit >= 0)
                    slot_live[hit] = 1'b0;
            end
            default:
            begin
                // unused command: nothing happens
            end
        endcase
    endtask

    // Compare one output beat with the oldest owed report
    task automatic check_report();
        report_t want;
        if (owed_reports.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected report: kind %0d id %0d time %0d last %0d",
                     $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                     m_axis_tlast);
        end
        else
        begin
            want = owed_reports.pop_front();
            if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.id ||
                m_axis_tdata[39:8] !== want.rpt_time || m_axis_tlast !== want.last)
            begin
                fail_count++;
                $display("%0t: report mismatch: expected kind %0d id %0d time %0d last %0d",
                         $time, want.kind, want.id, want.rpt_time, want.last);
                $display("%0t:                  got kind %0d id %0d time %0d last %0d",
                         $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                         m_axis_tlast);
            end
            if (want.kind == KIND_EXPIRED)
                expiries++;
            if (want.kind == KIND_SET_FULL)
                rejects++;
        end
    endtask

    // Channel watcher: beats are taken at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_now = '0;
            for (int i = 0; i < SLOTS; i++)
                slot_live[i] = 1'b0;
            owed_reports.delete();
            fail_count = 0;
            expiries   = 0;
            rejects    = 0;
            pending   <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_report();
            if (s_axis_tvalid && s_axis_tready)
                apply_command(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8]);
            pending <= owed_reports.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// Testbench top for the one-shot timer table: clock, reset, command stimulus,
// output back-pressure and the verdict.
// Depends on ostt_pkg, one_shot_timer_table_top and ostt_report_check.

module testbench;

    import ostt_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_BEATS = 386;
    localparam int         QUIET_BEATS  = 60;
    localparam int         SETTLE       = 4 * (SLOTS + 3);

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // timer_id[7:0], delay_ms[39:8]
    logic [1:0]  s_axis_tuser  = '0;   // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // report_id[7:0], report_time[39:8]
    logic [1:0]  m_axis_tuser;         // report_kind[1:0]
    logic        m_axis_tlast;         // last_report

    int          fail_count;
    int          pending;
    int          expiries;
    int          rejects;
    bit          stalls_on     = 1'b0;
    int          stall_left    = 0;
    int          sent [4]      = '{0, 0, 0, 0};

    one_shot_timer_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ostt_report_check report_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .expiries      (expiries),
        .rejects       (rejects)
    );

    // 8-unit clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output back-pressure in bursts of random length while stalls are on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 14);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Present one command beat and hold it until taken
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] id,
                             input logic [31:0] dur);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {dur, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent[cmd]++;
    endtask

    // Hold off until every owed report is out, then let the block settle
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin
        int unsigned pick;
        logic [1:0]  cmd;
        logic [7:0]  id;
        logic [31:0] dur;
        bit          busy_phase;
        busy_phase = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, zero and wrapping durations, two expiries at once
        send_beat(CMD_TICK, 8'h00, 32'h0000_0000);
        send_beat(CMD_SET, 8'h00, 32'h0000_0000);
        send_beat(CMD_SET, 8'hFF, 32'hFFFF_FFFF);
        send_beat(CMD_SET, 8'h5A, 32'h0000_0001);
        send_beat(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
        // re-arm an existing id, then fill the table and overflow it
        send_beat(CMD_SET, 8'hFF, 32'h0000_0003);
        send_beat(CMD_SET, 8'h01, 32'h0000_0002);
        send_beat(CMD_SET, 8'h02, 32'h0000_0002);
        send_beat(CMD_SET, 8'h03, 32'h0000_0002);
        send_beat(CMD_SET, 8'h04, 32'h0000_0002);
        send_beat(CMD_SET, 8'h09, 32'h0000_0002);
        // clear of an absent id and of a present one, then reuse the hole
        send_beat(CMD_CLEAR, 8'h09, 32'h0000_0000);
        send_beat(CMD_CLEAR, 8'h03, 32'h0000_0000);
        send_beat(CMD_SET, 8'h09, 32'h0000_0002);
        send_beat(CMD_UNUSED, 8'h04, 32'h0000_0001);
        send_beat(CMD_TICK, 8'h00, 32'h0000_0000);
        send_beat(CMD_TICK, 8'h00, 32'h0000_0000);
        send_beat(CMD_TICK, 8'h00, 32'h0000_0000);
        // every slot expiring on the same tick
        for (int i = 0; i < SLOTS; i++)
            send_beat(CMD_SET, 8'(8'h10 + i), 32'h0000_0001);
        send_beat(CMD_TICK, 8'h00, 32'h0000_0000);
        drain_reports();

        // Random: mostly ticks and sets over a small id pool so slots fill and expire
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n >= RANDOM_BEATS - QUIET_BEATS)
                busy_phase = 1'b0;
            else if (n % 50 == 0)
                busy_phase = ($urandom_range(0, 2) != 0);
            stalls_on <= busy_phase;
            if (n == RANDOM_BEATS / 2)
                drain_reports();
            if (busy_phase && $urandom_range(0, 3) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end

            pick = $urandom_range(0, 99);
            cmd  = (pick < 50) ? CMD_TICK : (pick < 85) ? CMD_SET :
                   (pick < 97) ? CMD_CLEAR : CMD_UNUSED;
            pick = $urandom_range(0, 9);
            id   = (pick < 8)  ? 8'($urandom_range(0, 7)) :
                   (pick == 8) ? 8'($urandom) : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
            pick = $urandom_range(0, 19);
            dur  = (pick < 14) ? 32'($urandom_range(0, 12)) :
                   (pick < 17) ? 32'($urandom_range(13, 80)) :
                   (pick < 19) ? 32'($urandom) : ~32'($urandom_range(0, 15));
            send_beat(cmd, id, dur);
        end

        // Drain and decide
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d ticks, %0d sets, %0d clears and %0d unused commands",
                 sent[CMD_TICK], sent[CMD_SET], sent[CMD_CLEAR], sent[CMD_UNUSED]);
        $display("seen %0d expiry reports and %0d table-full rejects", expiries, rejects);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ostt_pkg.sv
hdl/ostt_slot_ram.sv
hdl/one_shot_timer_table_top.sv
verif/ostt_report_check.sv
verif/testbench.sv
